// File: sv/pip_pkg.sv
// Shared types and constants for the point-in-polygon crossing test core.
`default_nettype none

package pip_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_W = 32;
	localparam int CROSS_W = 11;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_TEST   = 2'd2;

	localparam logic [1:0] REL_OUTSIDE   = 2'd0;
	localparam logic [1:0] REL_INSIDE    = 2'd1;
	localparam logic [1:0] REL_ON_VERTEX = 2'd2;
	localparam logic [1:0] REL_TOO_FEW   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FLUSH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic query;
		logic rd_req;
	} cmd_t;

	typedef struct packed {
		logic too_few;
		logic rd_last;
		logic pipe_idle;
	} stat_t;

endpackage

`default_nettype wire

// File: sv/point_in_polygon_crossing_test_core.sv
// Clear and append keep busy low, so a new beat may follow at once.
// A test with fewer than three vertices gives its result in the cycle after the beat.
// A test of n vertices keeps busy high while the vertex memory is read, n + 2 reads in all,
// then while a four-stage crossing pipeline drains, and through the result state.
// The result strobe done lasts one cycle; the receiver cannot stall it.
// Reset clears the vertex count, overflow flag and control; vertex memory is not cleared.
`default_nettype none

module point_in_polygon_crossing_test_core #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         operation,
	input  wire logic signed [pip_pkg::COORD_W-1:0] coord_x,
	input  wire logic signed [pip_pkg::COORD_W-1:0] coord_y,
	output logic                                    done,
	output logic [1:0]                              relation,
	output logic [pip_pkg::CROSS_W-1:0]             crossings,
	output logic                                    overflow
);

	pip_pkg::cmd_t  cmd;
	pip_pkg::stat_t stat;

	pip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	pip_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.stat      (stat),
		.relation  (relation),
		.crossings (crossings),
		.overflow  (overflow)
	);

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (relation == pip_pkg::REL_TOO_FEW || relation == pip_pkg::REL_ON_VERTEX)
		|-> (crossings == '0))
		else $error("nonzero crossings on special result");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		done && (relation == pip_pkg::REL_INSIDE || relation == pip_pkg::REL_OUTSIDE)
		|-> (crossings[0] == (relation == pip_pkg::REL_INSIDE)))
		else $error("relation disagrees with crossing parity");
`endif

endmodule

`default_nettype wire

// File: sv/pip_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/pip_ctrl.sv
// Controller state machine: sequences clear, append and ring scan.
`default_nettype none

module pip_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [1:0]   operation,
	input  wire pip_pkg::stat_t stat,
	output pip_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done
);

	pip_pkg::state_t state_q, state_nxt;
	logic            accept;

	assign accept = start && (state_q == pip_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pip_pkg::ST_IDLE: begin
				if (accept && operation == pip_pkg::OP_TEST) begin
					state_nxt = stat.too_few ? pip_pkg::ST_RESULT : pip_pkg::ST_READ;
				end
			end
			pip_pkg::ST_READ: begin
				if (stat.rd_last) begin
					state_nxt = pip_pkg::ST_FLUSH;
				end
			end
			pip_pkg::ST_FLUSH: begin
				if (stat.pipe_idle) begin
					state_nxt = pip_pkg::ST_RESULT;
				end
			end
			pip_pkg::ST_RESULT: begin
				state_nxt = pip_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = pip_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			pip_pkg::ST_IDLE: begin
				busy       = 1'b0;
				cmd.clear  = accept && (operation == pip_pkg::OP_CLEAR);
				cmd.append = accept && (operation == pip_pkg::OP_APPEND);
				cmd.query  = accept && (operation == pip_pkg::OP_TEST);
			end
			pip_pkg::ST_READ: begin
				cmd.rd_req = 1'b1;
			end
			pip_pkg::ST_FLUSH: begin
				cmd.rd_req = 1'b0;
			end
			pip_pkg::ST_RESULT: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/pip_dp.sv
// Datapath: vertex store, scan window, crossing pipeline and result.
`default_nettype none

module pip_dp #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pip_pkg::cmd_t                     cmd,
	input  wire logic signed [pip_pkg::COORD_W-1:0] coord_x,
	input  wire logic signed [pip_pkg::COORD_W-1:0] coord_y,
	output pip_pkg::stat_t                         stat,
	output logic [1:0]                             relation,
	output logic [pip_pkg::CROSS_W-1:0]            crossings,
	output logic                                   overflow
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int LW = $clog2(MAX_VERTICES + 2);
	localparam int W  = pip_pkg::COORD_W;

	// vertex count and flags
	logic [CW-1:0] count_q;
	logic          overflow_q;
	logic          full;

	// scan control
	logic [AW-1:0] rd_addr_q;
	logic [LW-1:0] rd_left_q;
	logic          rd_vld_q;
	logic [1:0]    fill_q;
	logic          win_vld_q;
	logic          vld_s1;
	logic          vld_s2;

	// query and window
	logic signed [W-1:0] qx_q, qy_q;
	logic signed [W-1:0] w_prev_x_q, w_cur_x_q, w_cur_y_q, w_nxt_x_q, w_nxt_y_q;
	logic [2*W-1:0]      rdata;

	// stage 1
	logic                hit, gate, straddle, between;
	logic signed [W:0]   a_c, dy_c, e_c, d_c;
	logic                hit_s1, vcnt_s1, edge_s1, dneg_s1;
	logic signed [W:0]   a_s1, dy_s1, e_s1, d_s1;

	// stage 2
	logic                hit_s2, vcnt_s2, edge_s2, dneg_s2;
	logic signed [2*W+1:0] p_s2, q_s2;
	logic                above;

	// accumulation
	logic [pip_pkg::CROSS_W-1:0] cnt_q;
	logic                        hit_q;
	logic                        short_q;

	assign full = (count_q == CW'(MAX_VERTICES));

	pip_ram #(
		.WIDTH (2 * W),
		.DEPTH (MAX_VERTICES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.append && !full),
		.waddr (count_q[AW-1:0]),
		.wdata ({coord_y, coord_x}),
		.re    (cmd.rd_req),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			rd_left_q  <= '0;
			rd_vld_q   <= 1'b0;
			fill_q     <= '0;
			win_vld_q  <= 1'b0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (cmd.append) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.query) begin
				rd_left_q <= LW'(count_q) + LW'(1);
				fill_q    <= '0;
			end else begin
				if (cmd.rd_req) begin
					rd_left_q <= rd_left_q - LW'(1);
				end
				if (rd_vld_q && fill_q != 2'd2) begin
					fill_q <= fill_q + 2'd1;
				end
			end
			rd_vld_q  <= cmd.rd_req;
			win_vld_q <= rd_vld_q && (fill_q == 2'd2);
			vld_s1    <= win_vld_q;
			vld_s2    <= vld_s1;
		end
	end

	// read order: last vertex, then 0 .. n-1, then 0 again
	always_ff @(posedge clk) begin
		if (cmd.query) begin
			rd_addr_q <= AW'(count_q - CW'(1));
			qx_q      <= coord_x;
			qy_q      <= coord_y;
		end else if (cmd.rd_req) begin
			rd_addr_q <= (rd_addr_q == AW'(count_q - CW'(1))) ? '0 : rd_addr_q + AW'(1);
		end
		if (rd_vld_q) begin
			w_prev_x_q <= w_cur_x_q;
			w_cur_x_q  <= w_nxt_x_q;
			w_cur_y_q  <= w_nxt_y_q;
			w_nxt_x_q  <= rdata[W-1:0];
			w_nxt_y_q  <= rdata[2*W-1:W];
		end
	end

	always_comb begin
		hit      = (w_cur_x_q == qx_q) && (w_cur_y_q == qy_q);
		gate     = (w_cur_y_q >= qy_q) || (w_nxt_y_q >= qy_q);
		straddle = ((w_prev_x_q < qx_q) && (qx_q <= w_nxt_x_q))
			|| ((w_nxt_x_q < qx_q) && (qx_q <= w_prev_x_q));
		between  = ((w_cur_x_q < qx_q) && (qx_q < w_nxt_x_q))
			|| ((w_nxt_x_q < qx_q) && (qx_q < w_cur_x_q));
		a_c  = {qx_q[W-1], qx_q} - {w_cur_x_q[W-1], w_cur_x_q};
		dy_c = {w_nxt_y_q[W-1], w_nxt_y_q} - {w_cur_y_q[W-1], w_cur_y_q};
		e_c  = {qy_q[W-1], qy_q} - {w_cur_y_q[W-1], w_cur_y_q};
		d_c  = {w_nxt_x_q[W-1], w_nxt_x_q} - {w_cur_x_q[W-1], w_cur_x_q};
	end

	always_ff @(posedge clk) begin
		hit_s1  <= hit;
		vcnt_s1 <= gate && (w_cur_x_q == qx_q) && straddle && (qy_q < w_cur_y_q);
		edge_s1 <= gate && between;
		dneg_s1 <= (w_nxt_x_q < w_cur_x_q);
		a_s1    <= a_c;
		dy_s1   <= dy_c;
		e_s1    <= e_c;
		d_s1    <= d_c;

		hit_s2  <= hit_s1;
		vcnt_s2 <= vcnt_s1;
		edge_s2 <= edge_s1;
		dneg_s2 <= dneg_s1;
		p_s2    <= a_s1 * dy_s1;
		q_s2    <= e_s1 * d_s1;
	end

	// edge crosses strictly above the query point
	assign above = dneg_s2 ? (p_s2 < q_s2) : (p_s2 > q_s2);

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			short_q <= (count_q < CW'(3));
		end else if (vld_s2) begin
			if (vcnt_s2 || (edge_s2 && above)) begin
				cnt_q <= cnt_q + pip_pkg::CROSS_W'(1);
			end
			if (hit_s2) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign stat.too_few   = (count_q < CW'(3));
	assign stat.rd_last   = (rd_left_q == '0);
	assign stat.pipe_idle = !(rd_vld_q || win_vld_q || vld_s1 || vld_s2);

	always_comb begin
		overflow  = overflow_q;
		crossings = cnt_q;
		if (short_q) begin
			relation  = pip_pkg::REL_TOO_FEW;
			crossings = '0;
		end else if (hit_q) begin
			relation  = pip_pkg::REL_ON_VERTEX;
			crossings = '0;
		end else if (cnt_q[0]) begin
			relation = pip_pkg::REL_INSIDE;
		end else begin
			relation = pip_pkg::REL_OUTSIDE;
		end
	end

endmodule

`default_nettype wire
